/* design/pct_pkg.sv */
`default_nettype none
package pct_pkg;

  localparam int CoordBits    = 16;
  localparam int AccBits      = CoordBits + 1;
  localparam int ProdBits     = AccBits + 4;
  localparam int NumValues    = 6;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  localparam logic [AccBits-1:0]   MagLimit = AccBits'(1) << (CoordBits - 1);
  localparam logic [CoordBits-1:0] MaxPos   = CoordBits'(MagLimit - AccBits'(1));

  // ASCII codes the parser looks at
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpZ  = 8'h5A;
  localparam logic [7:0] ChLoA  = 8'h61;
  localparam logic [7:0] ChLoZ  = 8'h7A;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef coord_t [NumValues-1:0] store_t;
  typedef logic [2:0] vcount_t;
  typedef logic [QueuePtrBits-1:0] qptr_t;
  typedef logic [QueuePtrBits:0] qcount_t;

  typedef enum logic [3:0] {
    CMD_M       = 4'd0,
    CMD_L       = 4'd1,
    CMD_H       = 4'd2,
    CMD_V       = 4'd3,
    CMD_Q       = 4'd4,
    CMD_T       = 4'd5,
    CMD_C       = 4'd6,
    CMD_S       = 4'd7,
    CMD_Z       = 4'd8,
    CMD_UNKNOWN = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } pct_in_t;

  typedef struct packed {
    logic [3:0] command;
    logic       relative;
    logic [1:0] point_count;
    logic [2:0] values_found;
    coord_t     x_first;
    coord_t     y_first;
    coord_t     x_second;
    coord_t     y_second;
    coord_t     x_third;
    coord_t     y_third;
    logic       end_of_path;
  } pct_out_t;

  // finished command as it sits in the queue
  typedef struct packed {
    cmd_t    command;
    logic    relative;
    vcount_t values_found;
    store_t  coords;
    logic    end_of_path;
  } pct_rec_t;

  typedef struct packed {
    logic first;
    logic second;
  } pct_push_t;

  typedef struct packed {
    logic    head_valid;
    logic    room;
    qcount_t count;
  } pct_qstat_t;

  function automatic cmd_t letter_code(input logic [7:0] up);
    cmd_t c;
    unique case (up)
      8'h4D:   c = CMD_M;
      8'h4C:   c = CMD_L;
      8'h48:   c = CMD_H;
      8'h56:   c = CMD_V;
      8'h51:   c = CMD_Q;
      8'h54:   c = CMD_T;
      8'h43:   c = CMD_C;
      8'h53:   c = CMD_S;
      8'h5A:   c = CMD_Z;
      default: c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/pct_front.sv */
`default_nettype none
module pct_front import pct_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire pct_in_t    in_data,
  input  wire pct_qstat_t qstat,
  output pct_push_t       push,
  output pct_rec_t        rec_a,
  output pct_rec_t        rec_b
);

  cmd_t                 pend_cmd, pend_cmd_next;
  logic                 pend_rel, pend_rel_next;
  logic                 active, active_next;
  vcount_t              vidx, fin_vidx, vidx_next, s2_vidx;
  logic [AccBits-1:0]   acc, acc_next;
  logic                 neg, neg_next;
  logic                 in_num, in_num_next;
  store_t               store, fin_store, store_next, s2_store;
  logic                 accept, upper, lower, letter, digit, minus;
  logic [7:0]           ch;
  logic [ProdBits-1:0]  prod;

  function automatic coord_t fin_value(input logic [AccBits-1:0] a, input logic n);
    logic [AccBits-1:0] negated;
    negated = AccBits'(0) - a;
    if (n) begin
      return negated[CoordBits-1:0];
    end
    if (a > MagLimit - AccBits'(1)) begin
      return MaxPos;
    end
    return a[CoordBits-1:0];
  endfunction

  assign in_stall = ~qstat.room;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    ch     = in_data.char_code;
    upper  = (ch >= ChUpA) && (ch <= ChUpZ);
    lower  = (ch >= ChLoA) && (ch <= ChLoZ);
    letter = upper | lower;
    digit  = (ch >= ChZero) && (ch <= ChNine);
    minus  = (ch == ChMinus);
    prod   = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(ProdBits-4){1'b0}}, ch[3:0]};

    // close the number in progress on the current state
    fin_store = store;
    fin_vidx  = vidx;
    if (in_num && (vidx < vcount_t'(NumValues))) begin
      fin_store[vidx] = fin_value(acc, neg);
      fin_vidx        = vidx + vcount_t'(1);
    end

    rec_a = '{command: pend_cmd, relative: pend_rel, values_found: fin_vidx,
              coords: fin_store, end_of_path: 1'b0};

    // state after this character
    pend_cmd_next = pend_cmd;
    pend_rel_next = pend_rel;
    active_next   = active;
    vidx_next     = vidx;
    acc_next      = acc;
    neg_next      = neg;
    in_num_next   = in_num;
    store_next    = store;
    if (letter) begin
      pend_cmd_next = letter_code(upper ? ch : ch - CaseGap);
      pend_rel_next = lower;
      active_next   = 1'b1;
      vidx_next     = '0;
      acc_next      = '0;
      neg_next      = 1'b0;
      in_num_next   = 1'b0;
      store_next    = '0;
    end else if (active) begin
      if (digit) begin
        acc_next    = (prod > ProdBits'(MagLimit)) ? MagLimit : prod[AccBits-1:0];
        in_num_next = 1'b1;
      end else begin
        store_next  = fin_store;
        vidx_next   = fin_vidx;
        in_num_next = 1'b0;
        acc_next    = '0;
        neg_next    = minus;
      end
    end

    // end of text closes the number left open by this character
    s2_store = store_next;
    s2_vidx  = vidx_next;
    if (in_num_next && (vidx_next < vcount_t'(NumValues))) begin
      s2_store[vidx_next] = fin_value(acc_next, neg_next);
      s2_vidx             = vidx_next + vcount_t'(1);
    end

    rec_b = '{command: pend_cmd_next, relative: pend_rel_next, values_found: s2_vidx,
              coords: s2_store, end_of_path: 1'b1};

    push.first  = accept & letter & active;
    push.second = accept & in_data.end_of_text & active_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.end_of_text)) begin
      pend_cmd <= CMD_M;
      pend_rel <= 1'b0;
      active   <= 1'b0;
      vidx     <= '0;
      acc      <= '0;
      neg      <= 1'b0;
      in_num   <= 1'b0;
      store    <= '0;
    end else if (accept) begin
      pend_cmd <= pend_cmd_next;
      pend_rel <= pend_rel_next;
      active   <= active_next;
      vidx     <= vidx_next;
      acc      <= acc_next;
      neg      <= neg_next;
      in_num   <= in_num_next;
      store    <= store_next;
    end
  end

endmodule
`default_nettype wire

/* design/pct_queue.sv */
`default_nettype none
module pct_queue import pct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pct_push_t push,
  input  wire pct_rec_t  rec_a,
  input  wire pct_rec_t  rec_b,
  input  wire logic      pop,
  output pct_qstat_t     qstat,
  output pct_rec_t       head
);

  pct_rec_t entries [QueueDepth];
  qptr_t    wr_ptr, rd_ptr, b_ptr;
  qcount_t  count, count_next;
  qcount_t  push_n;

  assign push_n = qcount_t'(push.first) + qcount_t'(push.second);
  assign b_ptr  = push.first ? wr_ptr + qptr_t'(1) : wr_ptr;
  assign count_next = count + push_n - qcount_t'(pop);

  assign qstat.head_valid = (count != '0);
  // two free slots needed: one request may leave two commands
  assign qstat.room       = (count <= qcount_t'(QueueDepth - 2));
  assign qstat.count      = count;
  assign head             = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QueuePtrBits-1:0];
      rd_ptr <= rd_ptr + qptr_t'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= rec_a;
    end
    if (push.second) begin
      entries[b_ptr] <= rec_b;
    end
  end

endmodule
`default_nettype wire

/* design/pct_back.sv */
`default_nettype none
module pct_back import pct_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pct_qstat_t qstat,
  input  wire pct_rec_t   head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output pct_out_t        out_data
);

  pct_out_t fmt;
  store_t   xy;
  logic     load;

  assign load = ~out_valid | ~out_stall;
  assign pop  = qstat.head_valid & load;

  always_comb begin
    xy = '0;
    fmt.point_count = 2'd0;
    unique case (head.command)
      CMD_M, CMD_L, CMD_T: begin
        fmt.point_count = 2'd1;
        xy[0] = head.coords[0];
        xy[1] = head.coords[1];
      end
      CMD_H: begin
        fmt.point_count = 2'd1;
        xy[0] = head.coords[0];
      end
      CMD_V: begin
        fmt.point_count = 2'd1;
        xy[1] = head.coords[0];
      end
      CMD_Q, CMD_S: begin
        fmt.point_count = 2'd2;
        xy[3:0] = head.coords[3:0];
      end
      CMD_C: begin
        fmt.point_count = 2'd3;
        xy = head.coords;
      end
      default: begin
        fmt.point_count = 2'd0;
      end
    endcase
    fmt.command      = head.command;
    fmt.relative     = head.relative;
    fmt.values_found = head.values_found;
    fmt.x_first      = xy[0];
    fmt.y_first      = xy[1];
    fmt.x_second     = xy[2];
    fmt.y_second     = xy[3];
    fmt.x_third      = xy[4];
    fmt.y_third      = xy[5];
    fmt.end_of_path  = head.end_of_path;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= qstat.head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= fmt;
    end
  end

endmodule
`default_nettype wire

/* design/path_command_tokenizer_core.sv */
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   pct_in_t  (char_code, end_of_text)
// out       output     out_valid / out_stall pct_out_t (one path command)
//
// One character is accepted per cycle while in_stall is low; it may leave zero,
// one or two commands. A command is parsed into the 4-entry queue when the character
// that ends it is accepted, then formatted into the output register when popped.
// in_stall rises while fewer than two queue slots are free, so it follows
// out_stall only once the queue has filled; the parser never waits otherwise.
// rst is synchronous and clears the parser state, the queue and out_valid.
module path_command_tokenizer_core import pct_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire pct_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output pct_out_t     out_data
);

  pct_qstat_t qstat;
  pct_push_t  push;
  pct_rec_t   rec_a, rec_b, head;
  logic       pop;

  // front: character classification, number accumulation, command framing
  pct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .rec_a    (rec_a),
    .rec_b    (rec_b)
  );

  // queue of finished commands; takes up to two per cycle
  pct_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .rec_a (rec_a),
    .rec_b (rec_b),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  // back: point layout per command and the output register
  pct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= qcount_t'(QueueDepth))
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.count != '0)
    else $error("pop from empty command queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.first || push.second) |-> qstat.room)
    else $error("command pushed without queue room");

  a_z_no_points: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.command == CMD_Z || out_data.command == CMD_UNKNOWN))
      |-> (out_data.point_count == 2'd0 && out_data.x_first == '0
           && out_data.y_first == '0))
    else $error("close or unknown command carries points");

endmodule
`default_nettype wire
